// File: rtl/xcs_pkg.sv
`timescale 1ns / 1ps
package xcs_pkg;

    localparam int BLOCK_BYTES = 128;
    localparam int BLK_AW      = $clog2(BLOCK_BYTES);
    localparam int HDR_BYTES   = 3;
    // slot index of the CRC high byte; the low byte follows it
    localparam logic [7:0] CRC_HI_INDEX = 8'(HDR_BYTES + BLOCK_BYTES);

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] B_SOH = 8'h01;
    localparam logic [7:0] B_EOT = 8'h04;
    localparam logic [7:0] B_ACK = 8'h06;
    localparam logic [7:0] B_NAK = 8'h15;
    localparam logic [7:0] B_CAN = 8'h18;
    localparam logic [7:0] B_C   = 8'h43;
    localparam logic [7:0] B_EOF = 8'h1A;

    localparam logic [2:0] ST_BUSY      = 3'd0;
    localparam logic [2:0] ST_READY     = 3'd1;
    localparam logic [2:0] ST_COMPLETE  = 3'd2;
    localparam logic [2:0] ST_CANCELLED = 3'd3;
    localparam logic [2:0] ST_START_TO  = 3'd4;
    localparam logic [2:0] ST_REFUSED   = 3'd5;

    localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_EOT_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_RETRY_LIMIT = 2'd2;
    localparam logic [1:0] CFG_PAD_VALUE   = 2'd3;

    typedef enum logic [2:0] {
        CMD_START  = 3'd0,
        CMD_DATA   = 3'd1,
        CMD_RX     = 3'd2,
        CMD_TICK   = 3'd3,
        CMD_SLOT   = 3'd4,
        CMD_FINISH = 3'd5,
        CMD_ABORT  = 3'd6,
        CMD_BAD    = 3'd7
    } cmd_t;

    typedef struct packed {
        logic is_c;
        logic is_ack;
        logic is_nak;
        logic is_eof;
    } rx_flags_t;

    typedef struct packed {
        cmd_t      cmd;
        logic [7:0] value;
        logic      last;
        rx_flags_t rx;
    } item_t;

    typedef struct packed {
        logic [15:0] ack_timeout;
        logic [15:0] eot_timeout;
        logic [7:0]  retry_limit;
        logic [7:0]  pad_value;
    } cfg_t;

    typedef enum logic [11:0] {
        PH_IDLE         = 12'h001,
        PH_WAIT_C       = 12'h002,
        PH_FILL         = 12'h004,
        PH_SEND         = 12'h008,
        PH_WAIT_ACK     = 12'h010,
        PH_EOT_FIRST    = 12'h020,
        PH_WAIT_EOT_ACK = 12'h040,
        PH_EOT_LAST     = 12'h080,
        PH_CAN_PEND     = 12'h100,
        PH_DONE         = 12'h200,
        PH_CANCELLED    = 12'h400,
        PH_START_TO     = 12'h800
    } phase_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int k;
        c = crc ^ {b, 8'h00};
        for (k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// File: rtl/xcs_ram.sv
`timescale 1ns / 1ps
module xcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/xcs_front.sv
`timescale 1ns / 1ps
module xcs_front (
    input  logic [2:0]         func,
    input  logic [7:0]         value,
    input  logic               last,
    output xcs_pkg::item_t     item
);

    xcs_pkg::cmd_t cmd;

    always_comb begin
        case (func)
            3'd0:    cmd = xcs_pkg::CMD_START;
            3'd1:    cmd = xcs_pkg::CMD_DATA;
            3'd2:    cmd = xcs_pkg::CMD_RX;
            3'd3:    cmd = xcs_pkg::CMD_TICK;
            3'd4:    cmd = xcs_pkg::CMD_SLOT;
            3'd5:    cmd = xcs_pkg::CMD_FINISH;
            3'd6:    cmd = xcs_pkg::CMD_ABORT;
            default: cmd = xcs_pkg::CMD_BAD;
        endcase
    end

    // classify partner bytes ahead of the sequencer
    always_comb begin
        item.cmd       = cmd;
        item.value     = value;
        item.last      = last;
        item.rx.is_c   = (value == xcs_pkg::B_C);
        item.rx.is_ack = (value == xcs_pkg::B_ACK);
        item.rx.is_nak = (value == xcs_pkg::B_NAK);
        item.rx.is_eof = (value == xcs_pkg::B_EOF);
    end

endmodule

// File: rtl/xcs_queue.sv
`timescale 1ns / 1ps
module xcs_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  xcs_pkg::item_t     push_item,
    output logic               ready,
    input  logic               pop,
    output logic               valid,
    output xcs_pkg::item_t     head
);

    xcs_pkg::item_t             slot_reg [xcs_pkg::Q_DEPTH];
    logic [xcs_pkg::Q_AW-1:0]   wr_ptr_reg;
    logic [xcs_pkg::Q_AW-1:0]   rd_ptr_reg;
    logic [xcs_pkg::Q_CW-1:0]   count_reg;
    logic [xcs_pkg::Q_CW-1:0]   count_next;
    logic                       do_push;
    logic                       do_pop;

    assign ready   = (count_reg != xcs_pkg::Q_CW'(xcs_pkg::Q_DEPTH));
    assign valid   = (count_reg != '0);
    assign do_push = push && ready;
    assign do_pop  = pop && valid;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/xcs_back.sv
`timescale 1ns / 1ps
module xcs_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  xcs_pkg::cfg_t      cfg,
    input  logic               q_valid,
    input  xcs_pkg::item_t     item,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata
);

    xcs_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  fill_count_reg, fill_count_next;
    logic [7:0]  block_number_reg, block_number_next;
    logic [7:0]  retry_count_reg, retry_count_next;
    logic [15:0] wait_ticks_reg, wait_ticks_next;
    logic [7:0]  send_index_reg, send_index_next;
    logic [15:0] crc_reg, crc_next;
    logic        final_reg, final_next;

    logic        m_valid_reg;
    logic [15:0] m_data_reg;

    logic        fire;
    logic        txv;
    logic [7:0]  txb;
    logic        refused;
    logic [2:0]  status;
    logic [7:0]  data_index;
    logic [7:0]  fill_inc;
    logic [16:0] tick_sum;
    logic [15:0] tick_limit;

    logic                       ram_we;
    logic [xcs_pkg::BLK_AW-1:0] ram_raddr;
    logic [7:0]                 ram_rdata;

    assign fire  = q_valid && (!m_valid_reg || m_tready);
    assign q_pop = fire;

    assign data_index = send_index_reg - 8'(xcs_pkg::HDR_BYTES);
    assign fill_inc   = fill_count_reg + 8'd1;
    assign tick_sum   = {1'b0, wait_ticks_reg} + 17'd1;
    assign tick_limit = (phase_reg == xcs_pkg::PH_WAIT_EOT_ACK) ? cfg.eot_timeout
                                                                  : cfg.ack_timeout;

    // prefetch the byte that the next data slot will take
    assign ram_raddr = xcs_pkg::BLK_AW'(send_index_next - 8'(xcs_pkg::HDR_BYTES));
    assign ram_we    = fire && (item.cmd == xcs_pkg::CMD_DATA)
                       && (phase_reg == xcs_pkg::PH_FILL)
                       && (fill_count_reg < 8'(xcs_pkg::BLOCK_BYTES));

    xcs_ram #(
        .WIDTH (8),
        .DEPTH (xcs_pkg::BLOCK_BYTES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (fill_count_reg[xcs_pkg::BLK_AW-1:0]),
        .wr_data (item.value),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb begin
        phase_next        = phase_reg;
        fill_count_next   = fill_count_reg;
        block_number_next = block_number_reg;
        retry_count_next  = retry_count_reg;
        wait_ticks_next   = wait_ticks_reg;
        send_index_next   = send_index_reg;
        crc_next          = crc_reg;
        final_next        = final_reg;
        txv               = 1'b0;
        txb               = 8'h00;
        refused           = 1'b0;

        if (fire) begin
            case (item.cmd)
                xcs_pkg::CMD_START: begin
                    phase_next        = xcs_pkg::PH_WAIT_C;
                    fill_count_next   = 8'd0;
                    block_number_next = 8'd1;
                    retry_count_next  = 8'd0;
                    wait_ticks_next   = 16'd0;
                    send_index_next   = 8'd0;
                    crc_next          = 16'd0;
                    final_next        = 1'b0;
                end
                xcs_pkg::CMD_DATA: begin
                    if (!ram_we) begin
                        refused = 1'b1;
                    end else begin
                        fill_count_next = fill_inc;
                        if (item.last || fill_inc >= 8'(xcs_pkg::BLOCK_BYTES)) begin
                            final_next      = item.last;
                            phase_next      = xcs_pkg::PH_SEND;
                            send_index_next = 8'd0;
                            crc_next        = 16'd0;
                        end
                    end
                end
                xcs_pkg::CMD_RX: begin
                    if (phase_reg == xcs_pkg::PH_WAIT_C) begin
                        if (item.rx.is_c) begin
                            phase_next      = xcs_pkg::PH_FILL;
                            fill_count_next = 8'd0;
                            final_next      = 1'b0;
                        end
                    end else if (phase_reg == xcs_pkg::PH_WAIT_ACK) begin
                        if (item.rx.is_ack) begin
                            block_number_next = block_number_reg + 8'd1;
                            retry_count_next  = 8'd0;
                            fill_count_next   = 8'd0;
                            final_next        = 1'b0;
                            phase_next        = xcs_pkg::PH_FILL;
                        end else if (item.rx.is_nak) begin
                            if (retry_count_reg > cfg.retry_limit) begin
                                phase_next = xcs_pkg::PH_CAN_PEND;
                            end else begin
                                if (retry_count_reg != 8'hFF) begin
                                    retry_count_next = retry_count_reg + 8'd1;
                                end
                                phase_next      = xcs_pkg::PH_SEND;
                                send_index_next = 8'd0;
                                crc_next        = 16'd0;
                            end
                        end else if (item.rx.is_eof) begin
                            phase_next = xcs_pkg::PH_EOT_LAST;
                        end
                    end else if (phase_reg == xcs_pkg::PH_WAIT_EOT_ACK) begin
                        if (item.rx.is_ack) begin
                            phase_next = xcs_pkg::PH_EOT_LAST;
                        end else if (item.rx.is_nak) begin
                            phase_next = xcs_pkg::PH_CAN_PEND;
                        end
                    end
                end
                xcs_pkg::CMD_TICK: begin
                    if (phase_reg == xcs_pkg::PH_WAIT_C || phase_reg == xcs_pkg::PH_WAIT_ACK
                        || phase_reg == xcs_pkg::PH_WAIT_EOT_ACK) begin
                        wait_ticks_next = tick_sum[15:0];
                        if (tick_sum >= {1'b0, tick_limit}) begin
                            wait_ticks_next = 16'd0;
                            if (phase_reg == xcs_pkg::PH_WAIT_C) begin
                                phase_next = xcs_pkg::PH_START_TO;
                            end else if (phase_reg == xcs_pkg::PH_WAIT_ACK) begin
                                if (retry_count_reg > cfg.retry_limit) begin
                                    phase_next = xcs_pkg::PH_CAN_PEND;
                                end else begin
                                    if (retry_count_reg != 8'hFF) begin
                                        retry_count_next = retry_count_reg + 8'd1;
                                    end
                                    phase_next      = xcs_pkg::PH_SEND;
                                    send_index_next = 8'd0;
                                    crc_next        = 16'd0;
                                end
                            end else begin
                                phase_next = xcs_pkg::PH_CAN_PEND;
                            end
                        end
                    end
                end
                xcs_pkg::CMD_SLOT: begin
                    if (phase_reg == xcs_pkg::PH_SEND) begin
                        txv             = 1'b1;
                        send_index_next = send_index_reg + 8'd1;
                        if (send_index_reg == 8'd0) begin
                            txb = xcs_pkg::B_SOH;
                        end else if (send_index_reg == 8'd1) begin
                            txb = block_number_reg;
                        end else if (send_index_reg == 8'd2) begin
                            txb = ~block_number_reg;
                        end else if (send_index_reg < xcs_pkg::CRC_HI_INDEX) begin
                            // pad past the fill point of a short final block
                            if (final_reg && data_index >= fill_count_reg) begin
                                txb = cfg.pad_value;
                            end else begin
                                txb = ram_rdata;
                            end
                            crc_next = xcs_pkg::crc_byte(crc_reg, txb);
                        end else if (send_index_reg == xcs_pkg::CRC_HI_INDEX) begin
                            txb = crc_reg[15:8];
                        end else begin
                            txb             = crc_reg[7:0];
                            phase_next      = xcs_pkg::PH_WAIT_ACK;
                            wait_ticks_next = 16'd0;
                        end
                    end else if (phase_reg == xcs_pkg::PH_EOT_FIRST) begin
                        txv             = 1'b1;
                        txb             = xcs_pkg::B_EOT;
                        phase_next      = xcs_pkg::PH_WAIT_EOT_ACK;
                        wait_ticks_next = 16'd0;
                    end else if (phase_reg == xcs_pkg::PH_EOT_LAST) begin
                        txv        = 1'b1;
                        txb        = xcs_pkg::B_EOT;
                        phase_next = xcs_pkg::PH_DONE;
                    end else if (phase_reg == xcs_pkg::PH_CAN_PEND) begin
                        txv        = 1'b1;
                        txb        = xcs_pkg::B_CAN;
                        phase_next = xcs_pkg::PH_CANCELLED;
                    end
                end
                xcs_pkg::CMD_FINISH: begin
                    if (phase_reg != xcs_pkg::PH_FILL) begin
                        refused = 1'b1;
                    end else begin
                        fill_count_next = 8'd0;
                        final_next      = 1'b0;
                        phase_next      = xcs_pkg::PH_EOT_FIRST;
                    end
                end
                xcs_pkg::CMD_ABORT: begin
                    phase_next = xcs_pkg::PH_CAN_PEND;
                end
                default: begin
                    refused = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        case (phase_next)
            xcs_pkg::PH_FILL:      status = xcs_pkg::ST_READY;
            xcs_pkg::PH_DONE:      status = xcs_pkg::ST_COMPLETE;
            xcs_pkg::PH_CANCELLED: status = xcs_pkg::ST_CANCELLED;
            xcs_pkg::PH_START_TO:  status = xcs_pkg::ST_START_TO;
            default:               status = xcs_pkg::ST_BUSY;
        endcase
        if (refused) begin
            status = xcs_pkg::ST_REFUSED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= xcs_pkg::PH_IDLE;
            fill_count_reg   <= 8'd0;
            block_number_reg <= 8'd1;
            retry_count_reg  <= 8'd0;
            wait_ticks_reg   <= 16'd0;
            send_index_reg   <= 8'd0;
            crc_reg          <= 16'd0;
            final_reg        <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            fill_count_reg   <= fill_count_next;
            block_number_reg <= block_number_next;
            retry_count_reg  <= retry_count_next;
            wait_ticks_reg   <= wait_ticks_next;
            send_index_reg   <= send_index_next;
            crc_reg          <= crc_next;
            final_reg        <= final_next;
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until the sink takes it
    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= {4'b0000, status, txb, txv};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == xcs_pkg::PH_FILL) |-> (fill_count_reg < 8'(xcs_pkg::BLOCK_BYTES)))
        else $error("fill count reached a full block while still filling");

    a_send_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == xcs_pkg::PH_SEND) |-> (send_index_reg <= xcs_pkg::CRC_HI_INDEX + 8'd1))
        else $error("send index ran past the CRC low byte");

    a_slot_sends: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && item.cmd == xcs_pkg::CMD_SLOT && phase_reg == xcs_pkg::PH_SEND)
        |=> (m_valid_reg && m_data_reg[0]))
        else $error("transmit slot during block send gave no line byte");

    a_bad_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && item.cmd == xcs_pkg::CMD_BAD)
        |=> (m_valid_reg && m_data_reg[11:9] == xcs_pkg::ST_REFUSED))
        else $error("unknown request not reported as refused");

endmodule

// File: rtl/xmodem_crc_block_sender.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake           Payload
// s_        in   s_tvalid/s_tready   tdata: value; tuser: func; tlast: last_of_data
// m_        out  m_tvalid/m_tready   tdata: tx_valid, tx_byte, status
// cfg_      in   cfg_wr_en           cfg_index selects register, cfg_wdata
//
// One request in, one result out; sustained rate one request per cycle while m_tready
// is held, each request passing through the front queue and then the result register.
// The block store is a 128 x 8 RAM read one slot ahead of the sequencer.
// Synchronous active-low reset clears control state; the store is not cleared.
// A stalled m_ side fills the two-entry queue, then drops s_tready.
module xmodem_crc_block_sender (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] value
    input  logic [2:0]  s_tuser,   // [2:0] func
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] tx_valid, [8:1] tx_byte, [11:9] status, rest zero
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    xcs_pkg::cfg_t  cfg_reg;
    xcs_pkg::item_t front_item;
    xcs_pkg::item_t head_item;
    logic           q_valid;
    logic           q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ack_timeout <= 16'd30000;
            cfg_reg.eot_timeout <= 16'd30000;
            cfg_reg.retry_limit <= 8'd15;
            cfg_reg.pad_value   <= 8'hFF;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                xcs_pkg::CFG_ACK_TIMEOUT: cfg_reg.ack_timeout <= cfg_wdata;
                xcs_pkg::CFG_EOT_TIMEOUT: cfg_reg.eot_timeout <= cfg_wdata;
                xcs_pkg::CFG_RETRY_LIMIT: cfg_reg.retry_limit <= cfg_wdata[7:0];
                xcs_pkg::CFG_PAD_VALUE:   cfg_reg.pad_value   <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    xcs_front u_front (
        .func  (s_tuser),
        .value (s_tdata),
        .last  (s_tlast),
        .item  (front_item)
    );

    xcs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid),
        .push_item (front_item),
        .ready     (s_tready),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (head_item)
    );

    xcs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .item     (head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
